@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/w2s_pkg.sv @@
package w2s_pkg;

  localparam int unsigned CoefWords = 38;
  localparam int unsigned IdxView   = 0;
  localparam int unsigned IdxProj   = 16;
  localparam int unsigned IdxCamPos = 32;
  localparam int unsigned IdxFwd    = 35;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BEHIND = 2'd1,
    STATUS_W_LOW  = 2'd2
  } status_t;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  // Saturate a 66-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    begin
      hi = 66'sd2147483647;
      lo = -66'sd2147483648;
      if (v > hi) sat32 = 32'sh7fffffff;
      else if (v < lo) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

endpackage

@@ rtl/w2s_div.sv @@
// Pipelined signed divider: quot = sat32((num << FRAC_BITS) / den), den > 0.
// One quotient bit per stage, truncating toward zero.
module w2s_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic signed [31:0] quot
);

  localparam int NB = 32 + FRAC_BITS;   // magnitude bits of the dividend
  localparam int QB = NB;               // quotient bits

  logic [NB-1:0] rem_num [0:NB];
  logic [32:0]   rem     [0:NB];
  logic [QB-1:0] q       [0:NB];
  logic [31:0]   dv      [0:NB];
  logic          neg     [0:NB];

  logic [31:0] mag;
  assign mag = num[31] ? (~num + 32'd1) : num;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_num[0] <= {mag, {FRAC_BITS{1'b0}}};
      rem[0]     <= '0;
      q[0]       <= '0;
      dv[0]      <= den;
      neg[0]     <= num[31];
    end
  end

  for (genvar i = 0; i < NB; i++) begin : g_stage
    logic [32:0] trial;
    logic [33:0] diff;
    assign trial = {rem[i][31:0], rem_num[i][NB-1]};
    assign diff  = {1'b0, trial} - {2'b00, dv[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_num[i+1] <= {rem_num[i][NB-2:0], 1'b0};
        rem[i+1]     <= diff[33] ? trial : diff[32:0];
        q[i+1]       <= {q[i][QB-2:0], ~diff[33]};
        dv[i+1]      <= dv[i];
        neg[i+1]     <= neg[i];
      end
    end
  end

  logic signed [65:0] sq;
  always_comb begin
    sq = $signed({{(66-QB){1'b0}}, q[NB]});
    if (neg[NB]) sq = -sq;
  end

  always_ff @(posedge clk) begin
    if (en) quot <= w2s_pkg::sat32(sq);
  end

endmodule

@@ rtl/world_to_screen_projection.sv @@
// World-to-screen perspective projection, signed Q(32-FRAC_BITS).FRAC_BITS.
// Input stream s_axis: tuser = operation (0 load coefficient, 1 project),
// tdata = coef_index, coef_value, point_x, point_y, point_z. A load writes
// one of 38 coefficient words (view matrix, projection matrix, camera
// position, camera forward) and gives no result; an index above 37 is
// ignored. A project item gives one result item on m_axis with status
// (0 ok, 1 behind camera, 2 clip w below 0.1), screen_x, screen_y, ndc_depth.
// The work is a fixed pipeline: offset/dot, view transform, projection,
// then a bit-per-stage divider (32+FRAC_BITS stages) and screen mapping.
// One item per cycle is taken unless the output stalls; Q16.16 by default.
// The whole pipeline advances only when its output stage is free or being
// taken, so a stalled receiver freezes it and nothing is lost or repeated.
// A load updates the store as the item enters; later items see it at once,
// earlier items still in flight keep the words they started with.
// Configuration (screen_width, screen_height) is written through cfg_*.
// Reset (rst, synchronous) clears the store to zero, valid bits in flight
// and sets width 1920, height 1080.
module world_to_screen_projection #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [13:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: coef_index[5:0], coef_value[37:6], point_x[69:38],
  // point_y[101:70], point_z[133:102], zeros to 135
  input  logic [135:0] s_axis_tdata,
  // tuser: operation
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status[1:0], screen_x[33:2], screen_y[65:34], ndc_depth[97:66],
  // zeros to 103
  output logic [103:0] m_axis_tdata
);

  `include "assert_macros.svh"

  localparam int DIVLAT = 32 + FRAC_BITS + 2;
  localparam logic signed [65:0] ONE = 66'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] THRESH = 32'((2**FRAC_BITS + 5) / 10);

  logic [13:0] screen_width, screen_height;
  logic signed [31:0] coef [0:w2s_pkg::CoefWords-1];

  logic adv;
  logic out_valid;
  assign adv = ~out_valid | m_axis_tready;
  assign s_axis_tready = adv;

  logic        acc_in;
  logic        op;
  logic [5:0]  cidx;
  logic signed [31:0] cval, px, py, pz;
  assign acc_in = s_axis_tvalid & s_axis_tready;
  assign op   = s_axis_tuser;
  assign cidx = s_axis_tdata[5:0];
  assign cval = s_axis_tdata[37:6];
  assign px   = s_axis_tdata[69:38];
  assign py   = s_axis_tdata[101:70];
  assign pz   = s_axis_tdata[133:102];

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 14'd1920;
      screen_height <= 14'd1080;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) screen_width <= cfg_data;
      else screen_height <= cfg_data;
    end
  end

  // Coefficient store: small register file, each word read at fixed places.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < w2s_pkg::CoefWords; i++) coef[i] <= '0;
    end else if (acc_in && op == w2s_pkg::OP_LOAD && cidx < 6'(w2s_pkg::CoefWords)) begin
      coef[cidx] <= cval;
    end
  end

  // Loads delayed in two registers: the projection copy below lags the store
  // so that the item in stage 4 sees the words of its own entry time.
  logic        ld1_we, ld2_we;
  logic [5:0]  ld1_idx, ld2_idx;
  logic signed [31:0] ld1_val, ld2_val;
  always_ff @(posedge clk) begin
    if (rst) begin
      ld1_we <= 1'b0;
      ld2_we <= 1'b0;
    end else if (adv) begin
      ld1_we <= acc_in && op == w2s_pkg::OP_LOAD;
      ld2_we <= ld1_we;
    end
    if (adv) begin
      ld1_idx <= cidx; ld1_val <= cval;
      ld2_idx <= ld1_idx; ld2_val <= ld1_val;
    end
  end

  logic signed [31:0] proj_coef [0:15];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) proj_coef[i] <= '0;
    end else if (adv && ld2_we && ld2_idx >= 6'(w2s_pkg::IdxProj)
                 && ld2_idx < 6'(w2s_pkg::IdxProj + 16)) begin
      proj_coef[4'(ld2_idx - 6'(w2s_pkg::IdxProj))] <= ld2_val;
    end
  end

  function automatic logic signed [65:0] qmul(input logic signed [31:0] a,
                                               input logic signed [32:0] b);
    logic signed [65:0] p;
    begin
      p = 66'(a) * 66'(b);
      qmul = p >>> FRAC_BITS;
    end
  endfunction

  // Stage 1: offset from camera, point captured.
  logic v1;
  logic signed [31:0] p1x, p1y, p1z, d1x, d1y, d1z;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= acc_in & (op == w2s_pkg::OP_PROJECT);
    if (adv) begin
      p1x <= px; p1y <= py; p1z <= pz;
      d1x <= w2s_pkg::sat32(66'(px) - 66'(coef[w2s_pkg::IdxCamPos]));
      d1y <= w2s_pkg::sat32(66'(py) - 66'(coef[w2s_pkg::IdxCamPos+1]));
      d1z <= w2s_pkg::sat32(66'(pz) - 66'(coef[w2s_pkg::IdxCamPos+2]));
    end
  end

  // Stage 2: dot product terms and view products (registered after multiply);
  // the translation column is captured here with the item.
  logic v2;
  logic signed [65:0] f2 [0:2];
  logic signed [65:0] m2 [0:3][0:2];
  logic signed [31:0] t2 [0:3];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      f2[0] <= qmul(d1x, 33'(coef[w2s_pkg::IdxFwd]));
      f2[1] <= qmul(d1y, 33'(coef[w2s_pkg::IdxFwd+1]));
      f2[2] <= qmul(d1z, 33'(coef[w2s_pkg::IdxFwd+2]));
      for (int r = 0; r < 4; r++) begin
        m2[r][0] <= qmul(coef[w2s_pkg::IdxView + r*4],     33'(p1x));
        m2[r][1] <= qmul(coef[w2s_pkg::IdxView + r*4 + 1], 33'(p1y));
        m2[r][2] <= qmul(coef[w2s_pkg::IdxView + r*4 + 2], 33'(p1z));
        t2[r]    <= coef[w2s_pkg::IdxView + r*4 + 3];
      end
    end
  end

  // Stage 3: sums, camera space.
  logic v3, behind3;
  logic signed [31:0] cam3 [0:3];
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      behind3 <= (f2[0] + f2[1] + f2[2]) <= 66'sd0;
      for (int r = 0; r < 4; r++)
        cam3[r] <= w2s_pkg::sat32(m2[r][0] + m2[r][1] + m2[r][2] + 66'(t2[r]));
    end
  end

  // Stage 4: projection products.
  logic v4, behind4;
  logic signed [65:0] m4 [0:3][0:3];
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      behind4 <= behind3;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          m4[r][c] <= qmul(proj_coef[r*4 + c], 33'(cam3[c]));
    end
  end

  // Stage 5: clip space.
  logic v5, behind5;
  logic signed [31:0] clip5 [0:3];
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
    if (adv) begin
      behind5 <= behind4;
      for (int r = 0; r < 4; r++)
        clip5[r] <= w2s_pkg::sat32(m4[r][0] + m4[r][1] + m4[r][2] + m4[r][3]);
    end
  end

  // Stage 6: status decision; w forced to 1 when low to keep divider sane.
  logic v6;
  w2s_pkg::status_t st6;
  logic signed [31:0] w6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (adv) v6 <= v5;
    if (adv) begin
      if (behind5) st6 <= w2s_pkg::STATUS_BEHIND;
      else if (clip5[3] < THRESH) st6 <= w2s_pkg::STATUS_W_LOW;
      else st6 <= w2s_pkg::STATUS_OK;
      w6 <= (clip5[3] < THRESH) ? 32'sd1 : clip5[3];
    end
  end

  logic signed [31:0] c6x, c6y, c6z;
  always_ff @(posedge clk) begin
    if (adv) begin
      c6x <= clip5[0]; c6y <= clip5[1]; c6z <= clip5[2];
    end
  end

  logic signed [31:0] ndcx, ndcy, ndcz;
  w2s_div #(.FRAC_BITS(FRAC_BITS)) u_divx (.clk, .en(adv), .num(c6x), .den(w6), .quot(ndcx));
  w2s_div #(.FRAC_BITS(FRAC_BITS)) u_divy (.clk, .en(adv), .num(c6y), .den(w6), .quot(ndcy));
  w2s_div #(.FRAC_BITS(FRAC_BITS)) u_divz (.clk, .en(adv), .num(c6z), .den(w6), .quot(ndcz));

  // Status and valid ride alongside the divider.
  logic              dv  [0:DIVLAT-1];
  w2s_pkg::status_t  dst [0:DIVLAT-1];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIVLAT; i++) dv[i] <= 1'b0;
    end else if (adv) begin
      dv[0] <= v6;
      for (int i = 1; i < DIVLAT; i++) dv[i] <= dv[i-1];
    end
    if (adv) begin
      dst[0] <= st6;
      for (int i = 1; i < DIVLAT; i++) dst[i] <= dst[i-1];
    end
  end

  // Mapping stage: products; output halves and saturates, zeroes rejects.
  logic vm;
  w2s_pkg::status_t stm;
  logic signed [65:0] sxm, sym;
  logic signed [31:0] nzm;
  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else if (adv) vm <= dv[DIVLAT-1];
    if (adv) begin
      stm <= dst[DIVLAT-1];
      sxm <= (66'(ndcx) + ONE) * $signed({52'd0, screen_width});
      sym <= (ONE - 66'(ndcy)) * $signed({52'd0, screen_height});
      nzm <= ndcz;
    end
  end

  w2s_pkg::status_t o_st;
  logic signed [31:0] o_x, o_y, o_z;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vm;
    if (adv) begin
      o_st <= stm;
      if (stm == w2s_pkg::STATUS_OK) begin
        o_x <= w2s_pkg::sat32(sxm >>> 1);
        o_y <= w2s_pkg::sat32(sym >>> 1);
        o_z <= nzm;
      end else begin
        o_x <= '0; o_y <= '0; o_z <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, o_z, o_y, o_x, o_st};

  `ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !m_axis_tready,
               out_valid && $stable(m_axis_tdata), "result changed while stalled")
  `ASSERT_IMPL(a_reject_zero, clk, rst,
               out_valid && o_st != w2s_pkg::STATUS_OK,
               o_x == 0 && o_y == 0 && o_z == 0, "rejected point has nonzero fields")
  `ASSERT_IMPL(a_ready, clk, rst, !out_valid, s_axis_tready, "not ready with empty output")

endmodule
